// ===== rtl/x931_pkg.sv =====
// shared types and constants for the x9.31 signature pad encoder
// command, status, register index and byte-kind codes; no dependencies
`default_nettype none

package x931_pkg;

   // command codes on req_command
   localparam logic [2:0] CMD_LOAD_EMPTY = 3'd0;
   localparam logic [2:0] CMD_LOAD_HASH  = 3'd1;
   localparam logic [2:0] CMD_PULL       = 3'd2;
   localparam logic [2:0] CMD_CHECK      = 3'd3;
   localparam logic [2:0] CMD_RESTART    = 3'd4;

   // status codes on rsp_status
   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_BAD_LEN   = 2'd1;
   localparam logic [1:0] STAT_TOO_SMALL = 2'd2;
   localparam logic [1:0] STAT_PAST_END  = 2'd3;

   // register indexes on csr_index
   localparam logic [1:0] CSR_OUTPUT_BITS = 2'd0;
   localparam logic [1:0] CSR_HASH_SIZE   = 2'd1;
   localparam logic [1:0] CSR_HASH_IDENT  = 2'd2;

   // register reset values
   localparam logic [13:0] OUTPUT_BITS_RST = 14'd2047;
   localparam logic [6:0]  HASH_SIZE_RST   = 7'd32;
   localparam logic [7:0]  HASH_IDENT_RST  = 8'd52;

   // fixed bytes of the padded block
   localparam logic [7:0] BYTE_HEAD_EMPTY = 8'h4B;
   localparam logic [7:0] BYTE_HEAD_MSG   = 8'h6B;
   localparam logic [7:0] BYTE_FILL       = 8'hBB;
   localparam logic [7:0] BYTE_SEP        = 8'hBA;
   localparam logic [7:0] BYTE_TRAILER    = 8'hCC;

   // byte counters saturate here
   localparam logic [6:0] CNT_MAX = 7'd127;

   typedef logic [2:0] sel_type;

   // which part of the block a position falls in
   localparam sel_type SEL_HEAD    = 3'd0;
   localparam sel_type SEL_FILL    = 3'd1;
   localparam sel_type SEL_SEP     = 3'd2;
   localparam sel_type SEL_HASH    = 3'd3;
   localparam sel_type SEL_IDENT   = 3'd4;
   localparam sel_type SEL_TRAILER = 3'd5;

   typedef struct packed {
      sel_type sel;       // byte kind at the current position
      logic    at_end;    // position is the last byte of the block
      logic    past_end;  // position at or beyond the block length
      logic    too_short; // block length below hash size plus four
   } layout_type;

endpackage

`default_nettype wire

// ===== rtl/x931_layout.sv =====
// position decode of the padded block: block length, byte kind and hash index
// depends on x931_pkg
`default_nettype none

module x931_layout import x931_pkg::*; #(
   parameter int MAX_HASH_BYTES = 64,
   parameter int MAX_OUT_BYTES  = 1024
) (
   input  wire logic [13:0]                        output_bits,
   input  wire logic [6:0]                         hash_size,
   input  wire logic [$clog2(MAX_OUT_BYTES+1)-1:0] position,
   output layout_type                              layout,
   output logic [$clog2(MAX_HASH_BYTES)-1:0]       hash_index
);

   localparam int AW = $clog2(MAX_HASH_BYTES);
   localparam int LW = $clog2(MAX_OUT_BYTES + 1);
   localparam int QW = 12;
   localparam int CW = (LW > QW) ? LW : QW;
   localparam int NW = ((LW > 7) ? LW : 7) + 2;

   logic [14:0]   bits_p1;
   logic [QW-1:0] len_raw;
   logic [LW-1:0] out_len;
   logic [NW-1:0] pn;
   logic [NW-1:0] ln;
   logic [NW-1:0] hn;
   logic [NW-1:0] hidx_wide;

   // length in bytes is (bits + 1) / 8, capped at the buffer size
   assign bits_p1 = {1'b0, output_bits} + 15'd1;
   assign len_raw = bits_p1[14:3];
   assign out_len = (CW'(len_raw) > CW'(MAX_OUT_BYTES)) ? LW'(MAX_OUT_BYTES) : LW'(len_raw);

   assign pn = NW'(position);
   assign ln = NW'(out_len);
   assign hn = NW'(hash_size);

   assign hidx_wide  = pn + hn + NW'(2) - ln;
   assign hash_index = hidx_wide[AW-1:0];

   always_comb begin
      layout.at_end    = (pn + NW'(1) == ln);
      layout.past_end  = (pn >= ln);
      layout.too_short = (ln < hn + NW'(4));
      priority if (pn == '0) begin
         layout.sel = SEL_HEAD;
      end else if (pn + NW'(3) + hn < ln) begin
         layout.sel = SEL_FILL;
      end else if (pn + hn + NW'(3) == ln) begin
         layout.sel = SEL_SEP;
      end else if (pn + NW'(2) == ln) begin
         layout.sel = SEL_IDENT;
      end else if (pn + NW'(1) == ln) begin
         layout.sel = SEL_TRAILER;
      end else begin
         layout.sel = SEL_HASH;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/x931_signature_pad_encoder.sv =====
// top level of the x9.31 signature pad encoder and checker
// depends on x931_pkg and x931_layout
`default_nettype none

// usage
//  - configuration: csr_write with csr_index 0 (output bits), 1 (hash size),
//    2 (hash ident) and csr_data; taken at the edge, no read-back
//  - commands: a word is taken at an edge with start high and busy low;
//    busy stays low, so one command can be issued every cycle
//  - commands load the empty hash, load the message hash, pull block bytes,
//    check coded bytes or rewind the position
//  - results: rsp_valid is high for one cycle with the word on the rsp_ ports;
//    the receiver cannot stall, it must take the word in that cycle
//  - a result passes through the command register (with the store read) and
//    then the result register
//  - throughput: one command per cycle; the hash stores are memories with
//    one write and one registered read each cycle
//  - a hash-load word without last, an empty-hash load and a restart give
//    no result
//  - reset: synchronous, active high; registers go to their defaults,
//    counters and position clear, both hash stores keep stale contents
module x931_signature_pad_encoder import x931_pkg::*; #(
   parameter int MAX_HASH_BYTES = 64,
   parameter int MAX_OUT_BYTES  = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // command channel
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_command,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last_flag,
   // result channel
   output logic             rsp_valid,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_out_last,
   output logic [1:0]       rsp_status,
   output logic             rsp_verify_ok,
   // register write port
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [13:0] csr_data
);

   localparam int AW = $clog2(MAX_HASH_BYTES);
   localparam int LW = $clog2(MAX_OUT_BYTES + 1);

   // configuration registers
   logic [13:0] output_bits_ff;
   logic [6:0]  hash_size_ff;
   logic [7:0]  hash_ident_ff;

   // command-side state
   logic [6:0]    empty_cnt_ff, empty_cnt_in;
   logic [6:0]    hash_cnt_ff, hash_cnt_in;
   logic          hash_done_ff, hash_done_in;
   logic [LW-1:0] pos_ff, pos_in;

   // result-side state
   logic matches_ff, matches_in;
   logic mismatch_ff, mismatch_in;

   // hash stores
   logic [7:0] empty_mem [MAX_HASH_BYTES];
   logic [7:0] hash_mem  [MAX_HASH_BYTES];
   logic [7:0] empty_rd_ff;
   logic [7:0] hash_rd_ff;

   // command register
   logic       s1_valid_ff, s1_valid_in;
   logic [2:0] s1_cmd_ff;
   logic [7:0] s1_data_ff;
   logic       s1_last_ff;
   logic [1:0] s1_status_ff, s1_status_in;
   logic       s1_ok_ff, s1_ok_in;
   sel_type    s1_sel_ff;
   logic [7:0] s1_ident_ff;
   logic       s1_at_end_ff;
   logic       s1_start_ff, s1_start_in;
   logic       s1_cmp_ff;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_last_ff, rsp_last_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic       rsp_verify_ff, rsp_verify_in;

   logic          accept;
   layout_type    layout;
   logic [AW-1:0] hash_index;
   logic [1:0]    status_cur;
   logic [1:0]    status_load;
   logic [6:0]    cnt_base;
   logic [6:0]    cnt_next;
   logic          cnt_in_range;
   logic          empty_in_range;
   logic [7:0]    block_byte;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   x931_layout #(
      .MAX_HASH_BYTES (MAX_HASH_BYTES),
      .MAX_OUT_BYTES  (MAX_OUT_BYTES)
   ) u_layout (
      .output_bits (output_bits_ff),
      .hash_size   (hash_size_ff),
      .position    (pos_ff),
      .layout      (layout),
      .hash_index  (hash_index)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         output_bits_ff <= OUTPUT_BITS_RST;
         hash_size_ff   <= HASH_SIZE_RST;
         hash_ident_ff  <= HASH_IDENT_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_OUTPUT_BITS: output_bits_ff <= csr_data;
            CSR_HASH_SIZE:   hash_size_ff   <= csr_data[6:0];
            CSR_HASH_IDENT:  hash_ident_ff  <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // a completed hash load restarts the count on the next hash byte
   assign cnt_base       = hash_done_ff ? 7'd0 : hash_cnt_ff;
   assign cnt_next       = (cnt_base != CNT_MAX) ? cnt_base + 7'd1 : cnt_base;
   assign cnt_in_range   = ({1'b0, cnt_base} < 8'(MAX_HASH_BYTES));
   assign empty_in_range = ({1'b0, empty_cnt_ff} < 8'(MAX_HASH_BYTES));

   // status from the state as it stands, and as it will stand after a hash byte
   always_comb begin
      if (!hash_done_ff || hash_cnt_ff != hash_size_ff) begin
         status_cur = STAT_BAD_LEN;
      end else if (layout.too_short) begin
         status_cur = STAT_TOO_SMALL;
      end else begin
         status_cur = STAT_OK;
      end
      if (cnt_next != hash_size_ff) begin
         status_load = STAT_BAD_LEN;
      end else if (layout.too_short) begin
         status_load = STAT_TOO_SMALL;
      end else begin
         status_load = STAT_OK;
      end
   end

   // command stage: counters, position and the word handed to the result stage
   always_comb begin
      empty_cnt_in = empty_cnt_ff;
      hash_cnt_in  = hash_cnt_ff;
      hash_done_in = hash_done_ff;
      pos_in       = pos_ff;
      s1_valid_in  = 1'b0;
      s1_status_in = STAT_OK;
      s1_ok_in     = 1'b0;
      s1_start_in  = 1'b0;
      if (accept) begin
         unique case (req_command)
            CMD_LOAD_EMPTY: begin
               empty_cnt_in = req_last_flag ? 7'd0 :
                              ((empty_cnt_ff != CNT_MAX) ? empty_cnt_ff + 7'd1 : empty_cnt_ff);
            end
            CMD_LOAD_HASH: begin
               s1_valid_in  = 1'b1;
               s1_start_in  = hash_done_ff;
               hash_cnt_in  = cnt_next;
               hash_done_in = req_last_flag;
               s1_status_in = status_load;
               if (hash_done_ff) begin
                  pos_in = '0;
               end
            end
            CMD_PULL, CMD_CHECK: begin
               s1_valid_in = 1'b1;
               if (status_cur != STAT_OK) begin
                  s1_status_in = status_cur;
               end else if (layout.past_end) begin
                  s1_status_in = STAT_PAST_END;
               end else begin
                  s1_ok_in = 1'b1;
                  pos_in   = pos_ff + LW'(1);
               end
               if (req_command == CMD_CHECK && req_last_flag) begin
                  pos_in = '0;
               end
            end
            CMD_RESTART: begin
               s1_valid_in = 1'b1;
               pos_in      = '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         empty_cnt_ff <= '0;
         hash_cnt_ff  <= '0;
         hash_done_ff <= 1'b0;
         pos_ff       <= '0;
         s1_valid_ff  <= 1'b0;
      end else begin
         empty_cnt_ff <= empty_cnt_in;
         hash_cnt_ff  <= hash_cnt_in;
         hash_done_ff <= hash_done_in;
         pos_ff       <= pos_in;
         s1_valid_ff  <= s1_valid_in;
      end
   end

   // command register payload
   always_ff @(posedge clock) begin
      s1_cmd_ff    <= req_command;
      s1_data_ff   <= req_data_byte;
      s1_last_ff   <= req_last_flag;
      s1_status_ff <= s1_status_in;
      s1_ok_ff     <= s1_ok_in;
      s1_sel_ff    <= layout.sel;
      s1_ident_ff  <= hash_ident_ff;
      s1_at_end_ff <= layout.at_end;
      s1_start_ff  <= s1_start_in;
      s1_cmp_ff    <= cnt_in_range;
   end

   // empty-hash store, read at the hash byte's index for the compare
   always_ff @(posedge clock) begin
      if (accept && req_command == CMD_LOAD_EMPTY && empty_in_range) begin
         empty_mem[empty_cnt_ff[AW-1:0]] <= req_data_byte;
      end
      empty_rd_ff <= empty_mem[cnt_base[AW-1:0]];
   end

   // message-hash store, read at the hash part of the block
   always_ff @(posedge clock) begin
      if (accept && req_command == CMD_LOAD_HASH && cnt_in_range) begin
         hash_mem[cnt_base[AW-1:0]] <= req_data_byte;
      end
      hash_rd_ff <= hash_mem[hash_index];
   end

   // block byte at the registered position
   always_comb begin
      unique case (s1_sel_ff)
         SEL_HEAD:    block_byte = matches_ff ? BYTE_HEAD_EMPTY : BYTE_HEAD_MSG;
         SEL_FILL:    block_byte = BYTE_FILL;
         SEL_SEP:     block_byte = BYTE_SEP;
         SEL_HASH:    block_byte = hash_rd_ff;
         SEL_IDENT:   block_byte = s1_ident_ff;
         SEL_TRAILER: block_byte = BYTE_TRAILER;
         default:     block_byte = BYTE_TRAILER;
      endcase
   end

   // result stage
   always_comb begin
      matches_in    = matches_ff;
      mismatch_in   = mismatch_ff;
      rsp_valid_in  = 1'b0;
      rsp_byte_in   = 8'd0;
      rsp_last_in   = 1'b0;
      rsp_status_in = s1_status_ff;
      rsp_verify_in = 1'b0;
      if (s1_valid_ff) begin
         unique case (s1_cmd_ff)
            CMD_LOAD_HASH: begin
               if (s1_start_ff) begin
                  matches_in  = 1'b1;
                  mismatch_in = 1'b0;
               end
               if (s1_cmp_ff && empty_rd_ff != s1_data_ff) begin
                  matches_in = 1'b0;
               end
               rsp_valid_in = s1_last_ff;
            end
            CMD_PULL: begin
               rsp_valid_in = 1'b1;
               if (s1_ok_ff) begin
                  rsp_byte_in = block_byte;
                  rsp_last_in = s1_at_end_ff;
               end
            end
            CMD_CHECK: begin
               rsp_valid_in = 1'b1;
               if (!s1_ok_ff || block_byte != s1_data_ff) begin
                  mismatch_in = 1'b1;
               end
               if (s1_last_ff) begin
                  // all bytes matched and the last one closed the block
                  rsp_verify_in = s1_ok_ff && !mismatch_in && s1_at_end_ff;
                  mismatch_in   = 1'b0;
               end
            end
            CMD_RESTART: begin
               mismatch_in = 1'b0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         matches_ff   <= 1'b1;
         mismatch_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         matches_ff   <= matches_in;
         mismatch_ff  <= mismatch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff   <= rsp_byte_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_verify_ff <= rsp_verify_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_byte_ff;
   assign rsp_out_last  = rsp_last_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_verify_ok = rsp_verify_ff;

endmodule

`default_nettype wire
